@@ design/fire_zone_table_point_check_macros.svh @@
// Assertion macros shared by the fire zone table design
`ifndef FIRE_ZONE_TABLE_POINT_CHECK_MACROS_SVH
`define FIRE_ZONE_TABLE_POINT_CHECK_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check that pre implies post in the same cycle
`define FZT_ASSERT_SAME(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);
// Check that pre implies post in the next cycle
`define FZT_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);
`else
`define FZT_ASSERT_SAME(label, pre, post, msg)
`define FZT_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

@@ design/fzt_pkg.sv @@
package fzt_pkg;

   localparam int COORD_BITS = 24;
   localparam int PRIORITY_ZONES_DEF = 16;
   localparam int NOFIRE_ZONES_DEF = 4;

   typedef enum logic [3:0] {
      KIND_ADD_PFZ    = 4'd0,
      KIND_ADD_NFZ    = 4'd1,
      KIND_DEL_PFZ    = 4'd2,
      KIND_DEL_NFZ    = 4'd3,
      KIND_NEXT       = 4'd4,
      KIND_PREVIOUS   = 4'd5,
      KIND_DESELECT   = 4'd6,
      KIND_DEL_CURRENT = 4'd7,
      KIND_CHECK      = 4'd8
   } kind_type;

   typedef struct packed {
      logic [3:0]                    kind;
      logic [3:0]                    zone_index;
      logic signed [COORD_BITS-1:0]  point_x;
      logic signed [COORD_BITS-1:0]  point_z;
      logic signed [COORD_BITS-1:0]  corner1_x;
      logic signed [COORD_BITS-1:0]  corner1_z;
      logic signed [COORD_BITS-1:0]  corner2_x;
      logic signed [COORD_BITS-1:0]  corner2_z;
      logic signed [COORD_BITS-1:0]  corner3_x;
      logic signed [COORD_BITS-1:0]  corner3_z;
      logic signed [COORD_BITS-1:0]  corner4_x;
      logic signed [COORD_BITS-1:0]  corner4_z;
   } req_type;

   typedef struct packed {
      logic       target_valid;
      logic       status;
      logic       zone_selected;
      logic [3:0] selected_zone;
      logic [4:0] priority_count;
      logic [2:0] nofire_count;
   } rsp_type;

endpackage

@@ design/fzt_ram.sv @@
module fzt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/fire_zone_table_point_check.sv @@
// A delete moves each later zone down one slot; an add to a full table first drops zone 0 that way.
// Select and unknown commands only build the response.
// A check tests at most the current zone and every no-fire zone.
// One request at a time: the next one is accepted once its response has loaded and the block idles;
// the corner words read from the tables feed a single shared 25x25 multiplier, two products per edge.
// Reset (synchronous, active high) empties both tables and clears the selection; contents stay.
`include "fire_zone_table_point_check_macros.svh"

module fire_zone_table_point_check import fzt_pkg::*; #(
   parameter int PRIORITY_ZONES = PRIORITY_ZONES_DEF,
   parameter int NOFIRE_ZONES = NOFIRE_ZONES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int PZW = (PRIORITY_ZONES > 1) ? $clog2(PRIORITY_ZONES) : 1;
   localparam int NZW = (NOFIRE_ZONES > 1) ? $clog2(NOFIRE_ZONES) : 1;
   localparam int ZW = (PZW > NZW) ? PZW : NZW;
   localparam int PCW = $clog2(PRIORITY_ZONES + 1);
   localparam int NCW = $clog2(NOFIRE_ZONES + 1);
   localparam int CW0 = (PCW > NCW) ? PCW : NCW;
   localparam int CMPW = ((CW0 > 4) ? CW0 : 4) + 1;
   localparam int PDEPTH = 8 << PZW;
   localparam int NDEPTH = 8 << NZW;
   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DISPATCH, ST_SH_RD, ST_SH_WR, ST_SH_END, ST_WRITE,
      ST_LD_RD, ST_LD_CAP, ST_EDGE_L, ST_EDGE_R, ST_EDGE_C, ST_ZONE_END, ST_DONE
   } state_type;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      tbl_ff, tbl_in;
   logic      add_ff, add_in;
   logic [ZW-1:0]  zone_ff, zone_in;
   logic [2:0]     wptr_ff, wptr_in;
   logic [PCW-1:0] pcount_ff, pcount_in;
   logic [NCW-1:0] ncount_ff, ncount_in;
   logic           sel_ff, sel_in;
   logic [PZW-1:0] cur_ff, cur_in;
   logic           status_ff, status_in;
   logic           valid_ff, valid_in;
   logic [1:0]     edge_ff, edge_in;
   logic           neg_ff, neg_in;
   logic           inside_ff, inside_in;
   logic signed [COORD_BITS-1:0] ax_ff, ax_in, az_ff, az_in;
   logic signed [COORD_BITS-1:0] bx_ff, bx_in, bz_ff, bz_in;
   logic signed [COORD_BITS-1:0] fx_ff, fx_in, fz_ff, fz_in;
   logic signed [PW-1:0] lhs_ff, lhs_in, rhs_ff, rhs_in;

   logic                  p_we, n_we;
   logic [PZW+2:0]        p_waddr, p_raddr;
   logic [NZW+2:0]        n_waddr, n_raddr;
   logic [COORD_BITS-1:0] wdata, p_rdata, n_rdata, rdata, corner_word;
   logic [ZW-1:0]         zone_nxt;
   logic [CMPW-1:0]       tcnt, newc;
   logic signed [DW-1:0]  op1, op2;
   logic signed [PW-1:0]  product;
   logic                  lt, gt, fail;

   fzt_ram #(.WIDTH(COORD_BITS), .DEPTH(PDEPTH)) u_pri_ram (
      .clock(clock), .wr_en(p_we), .wr_addr(p_waddr), .wr_data(wdata),
      .rd_addr(p_raddr), .rd_data(p_rdata)
   );

   fzt_ram #(.WIDTH(COORD_BITS), .DEPTH(NDEPTH)) u_nf_ram (
      .clock(clock), .wr_en(n_we), .wr_addr(n_waddr), .wr_data(wdata),
      .rd_addr(n_raddr), .rd_data(n_rdata)
   );

   assign rdata = tbl_ff ? n_rdata : p_rdata;
   assign zone_nxt = zone_ff + ZW'(1);
   assign tcnt = tbl_ff ? CMPW'(ncount_ff) : CMPW'(pcount_ff);
   assign newc = CMPW'(pcount_ff) - CMPW'(1);

   // Pick the corner word of the held request for an append
   always_comb begin
      case (wptr_ff)
         3'd0: corner_word = req_ff.corner1_x;
         3'd1: corner_word = req_ff.corner1_z;
         3'd2: corner_word = req_ff.corner2_x;
         3'd3: corner_word = req_ff.corner2_z;
         3'd4: corner_word = req_ff.corner3_x;
         3'd5: corner_word = req_ff.corner3_z;
         3'd6: corner_word = req_ff.corner4_x;
         default: corner_word = req_ff.corner4_z;
      endcase
   end

   // Shared edge multiplier: lhs term in EDGE_L, rhs term otherwise
   always_comb begin
      if (state_ff == ST_EDGE_L) begin
         op1 = DW'(req_ff.point_z) - DW'(az_ff);
         op2 = DW'(bx_ff) - DW'(ax_ff);
      end else begin
         op1 = DW'(req_ff.point_x) - DW'(ax_ff);
         op2 = DW'(bz_ff) - DW'(az_ff);
      end
   end

   assign product = op1 * op2;
   assign lt = lhs_ff < rhs_ff;
   assign gt = lhs_ff > rhs_ff;
   assign fail = (edge_ff != 2'd0) && ((neg_ff && gt) || (!neg_ff && lt));

   // Table memory ports
   always_comb begin
      p_we = 1'b0;
      n_we = 1'b0;
      wdata = rdata;
      p_waddr = {PZW'(zone_ff), wptr_ff};
      n_waddr = {NZW'(zone_ff), wptr_ff};
      p_raddr = {PZW'(zone_ff), wptr_ff};
      n_raddr = {NZW'(zone_ff), wptr_ff};
      case (state_ff)
         ST_SH_RD: begin
            p_raddr = {PZW'(zone_nxt), wptr_ff};
            n_raddr = {NZW'(zone_nxt), wptr_ff};
         end
         ST_SH_WR: begin
            p_we = !tbl_ff;
            n_we = tbl_ff;
         end
         ST_WRITE: begin
            p_we = !tbl_ff;
            n_we = tbl_ff;
            wdata = corner_word;
         end
         default: begin
         end
      endcase
   end

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      tbl_in = tbl_ff;
      add_in = add_ff;
      zone_in = zone_ff;
      wptr_in = wptr_ff;
      pcount_in = pcount_ff;
      ncount_in = ncount_ff;
      sel_in = sel_ff;
      cur_in = cur_ff;
      status_in = status_ff;
      valid_in = valid_ff;
      edge_in = edge_ff;
      neg_in = neg_ff;
      inside_in = inside_ff;
      ax_in = ax_ff;
      az_in = az_ff;
      bx_in = bx_ff;
      bz_in = bz_ff;
      fx_in = fx_ff;
      fz_in = fz_ff;
      lhs_in = lhs_ff;
      rhs_in = rhs_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            status_in = 1'b0;
            valid_in = 1'b0;
            add_in = 1'b0;
            wptr_in = 3'd0;
            state_in = ST_DONE;
            case (req_ff.kind)
               KIND_ADD_PFZ: begin
                  tbl_in = 1'b0;
                  add_in = 1'b1;
                  if (CMPW'(pcount_ff) == CMPW'(PRIORITY_ZONES)) begin
                     zone_in = '0;
                     state_in = (CMPW'(pcount_ff) > CMPW'(1)) ? ST_SH_RD : ST_SH_END;
                  end else begin
                     zone_in = ZW'(pcount_ff);
                     state_in = ST_WRITE;
                  end
               end
               KIND_ADD_NFZ: begin
                  tbl_in = 1'b1;
                  add_in = 1'b1;
                  if (CMPW'(ncount_ff) == CMPW'(NOFIRE_ZONES)) begin
                     zone_in = '0;
                     state_in = (CMPW'(ncount_ff) > CMPW'(1)) ? ST_SH_RD : ST_SH_END;
                  end else begin
                     zone_in = ZW'(ncount_ff);
                     state_in = ST_WRITE;
                  end
               end
               KIND_DEL_PFZ: begin
                  tbl_in = 1'b0;
                  if (CMPW'(req_ff.zone_index) < CMPW'(pcount_ff)) begin
                     zone_in = ZW'(req_ff.zone_index);
                     state_in = (CMPW'(req_ff.zone_index) + CMPW'(1) < CMPW'(pcount_ff))
                        ? ST_SH_RD : ST_SH_END;
                  end else begin
                     status_in = 1'b1;
                  end
               end
               KIND_DEL_NFZ: begin
                  tbl_in = 1'b1;
                  if (CMPW'(req_ff.zone_index) < CMPW'(ncount_ff)) begin
                     zone_in = ZW'(req_ff.zone_index);
                     state_in = (CMPW'(req_ff.zone_index) + CMPW'(1) < CMPW'(ncount_ff))
                        ? ST_SH_RD : ST_SH_END;
                  end else begin
                     status_in = 1'b1;
                  end
               end
               KIND_NEXT: begin
                  if (pcount_ff == '0) begin
                     sel_in = 1'b0;
                     cur_in = '0;
                  end else if (!sel_ff) begin
                     sel_in = 1'b1;
                     cur_in = '0;
                  end else if (CMPW'(cur_ff) + CMPW'(1) >= CMPW'(pcount_ff)) begin
                     cur_in = '0;
                  end else begin
                     cur_in = cur_ff + PZW'(1);
                  end
               end
               KIND_PREVIOUS: begin
                  if (pcount_ff == '0) begin
                     sel_in = 1'b0;
                     cur_in = '0;
                  end else if (!sel_ff || cur_ff == '0) begin
                     sel_in = 1'b1;
                     cur_in = PZW'(newc);
                  end else begin
                     cur_in = cur_ff - PZW'(1);
                  end
               end
               KIND_DESELECT: begin
                  sel_in = 1'b0;
                  cur_in = '0;
               end
               KIND_DEL_CURRENT: begin
                  tbl_in = 1'b0;
                  if (sel_ff && CMPW'(cur_ff) < CMPW'(pcount_ff)) begin
                     zone_in = ZW'(cur_ff);
                     state_in = (CMPW'(cur_ff) + CMPW'(1) < CMPW'(pcount_ff))
                        ? ST_SH_RD : ST_SH_END;
                  end
               end
               KIND_CHECK: begin
                  valid_in = 1'b1;
                  if (sel_ff && CMPW'(cur_ff) < CMPW'(pcount_ff)) begin
                     tbl_in = 1'b0;
                     zone_in = ZW'(cur_ff);
                     state_in = ST_LD_RD;
                  end else if (ncount_ff != '0) begin
                     tbl_in = 1'b1;
                     zone_in = '0;
                     state_in = ST_LD_RD;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_SH_RD: begin
            state_in = ST_SH_WR;
         end
         ST_SH_WR: begin
            // Advance the copy one word; stop after the last entry moved down
            wptr_in = wptr_ff + 3'd1;
            state_in = ST_SH_RD;
            if (wptr_ff == 3'd7) begin
               zone_in = zone_nxt;
               if (CMPW'(zone_ff) + CMPW'(2) >= tcnt) begin
                  state_in = ST_SH_END;
               end
            end
         end
         ST_SH_END: begin
            wptr_in = 3'd0;
            state_in = add_ff ? ST_WRITE : ST_DONE;
            if (tbl_ff) begin
               ncount_in = ncount_ff - NCW'(1);
               zone_in = ZW'(ncount_ff - NCW'(1));
            end else begin
               pcount_in = PCW'(newc);
               zone_in = ZW'(newc);
               // Pull the selection back inside the shorter table
               if (sel_ff && CMPW'(cur_ff) >= newc) begin
                  if (newc == '0) begin
                     sel_in = 1'b0;
                     cur_in = '0;
                  end else if (cur_ff == '0) begin
                     cur_in = PZW'(newc - CMPW'(1));
                  end else begin
                     cur_in = cur_ff - PZW'(1);
                  end
               end
            end
         end
         ST_WRITE: begin
            wptr_in = wptr_ff + 3'd1;
            if (wptr_ff == 3'd7) begin
               state_in = ST_DONE;
               if (tbl_ff) begin
                  ncount_in = ncount_ff + NCW'(1);
               end else begin
                  pcount_in = pcount_ff + PCW'(1);
               end
            end
         end
         ST_LD_RD: begin
            state_in = ST_LD_CAP;
         end
         ST_LD_CAP: begin
            wptr_in = wptr_ff + 3'd1;
            state_in = ST_LD_RD;
            if (!wptr_ff[0]) begin
               bx_in = rdata;
            end else begin
               bz_in = rdata;
            end
            case (wptr_ff)
               3'd1: begin
                  ax_in = bx_ff;
                  az_in = rdata;
                  fx_in = bx_ff;
                  fz_in = rdata;
               end
               3'd3: begin
                  edge_in = 2'd0;
                  state_in = ST_EDGE_L;
               end
               3'd5, 3'd7: begin
                  state_in = ST_EDGE_L;
               end
               default: begin
               end
            endcase
         end
         ST_EDGE_L: begin
            lhs_in = product;
            state_in = ST_EDGE_R;
         end
         ST_EDGE_R: begin
            rhs_in = product;
            state_in = ST_EDGE_C;
         end
         ST_EDGE_C: begin
            if (edge_ff == 2'd0) begin
               neg_in = lt;
            end
            if (fail) begin
               inside_in = 1'b0;
               state_in = ST_ZONE_END;
            end else if (edge_ff == 2'd3) begin
               inside_in = 1'b1;
               state_in = ST_ZONE_END;
            end else begin
               // Slide to the next edge; close the loop back to corner one
               edge_in = edge_ff + 2'd1;
               ax_in = bx_ff;
               az_in = bz_ff;
               if (edge_ff == 2'd2) begin
                  bx_in = fx_ff;
                  bz_in = fz_ff;
                  state_in = ST_EDGE_L;
               end else begin
                  state_in = ST_LD_RD;
               end
            end
         end
         ST_ZONE_END: begin
            wptr_in = 3'd0;
            state_in = ST_DONE;
            if (!tbl_ff) begin
               if (!inside_ff) begin
                  valid_in = 1'b0;
               end else if (ncount_ff != '0) begin
                  tbl_in = 1'b1;
                  zone_in = '0;
                  state_in = ST_LD_RD;
               end
            end else if (inside_ff) begin
               valid_in = 1'b0;
            end else if (CMPW'(zone_ff) + CMPW'(1) < CMPW'(ncount_ff)) begin
               zone_in = zone_nxt;
               state_in = ST_LD_RD;
            end
         end
         ST_DONE: begin
            // Hold until the response register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in.target_valid = valid_ff;
               rsp_in.status = status_ff;
               rsp_in.zone_selected = sel_ff;
               rsp_in.selected_zone = sel_ff ? 4'(cur_ff) : 4'd0;
               rsp_in.priority_count = 5'(pcount_ff);
               rsp_in.nofire_count = 3'(ncount_ff);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pcount_ff <= '0;
         ncount_ff <= '0;
         sel_ff <= 1'b0;
         cur_ff <= '0;
         tbl_ff <= 1'b0;
         add_ff <= 1'b0;
         edge_ff <= 2'd0;
         wptr_ff <= 3'd0;
         zone_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pcount_ff <= pcount_in;
         ncount_ff <= ncount_in;
         sel_ff <= sel_in;
         cur_ff <= cur_in;
         tbl_ff <= tbl_in;
         add_ff <= add_in;
         edge_ff <= edge_in;
         wptr_ff <= wptr_in;
         zone_ff <= zone_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      status_ff <= status_in;
      valid_ff <= valid_in;
      neg_ff <= neg_in;
      inside_ff <= inside_in;
      ax_ff <= ax_in;
      az_ff <= az_in;
      bx_ff <= bx_in;
      bz_ff <= bz_in;
      fx_ff <= fx_in;
      fz_ff <= fz_in;
      lhs_ff <= lhs_in;
      rhs_ff <= rhs_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `FZT_ASSERT_SAME(a_pcount_max, 1'b1, CMPW'(pcount_ff) <= CMPW'(PRIORITY_ZONES), "priority count overflow")
   `FZT_ASSERT_SAME(a_ncount_max, 1'b1, CMPW'(ncount_ff) <= CMPW'(NOFIRE_ZONES), "no-fire count overflow")
   `FZT_ASSERT_SAME(a_sel_in_table, sel_ff, CMPW'(cur_ff) < CMPW'(pcount_ff), "selection beyond table")
   `FZT_ASSERT_SAME(a_nosel_zero, !sel_ff, cur_ff == '0, "current zone not cleared")
   `FZT_ASSERT_NEXT(a_done_loads, (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall), rsp_valid_ff && (state_ff == ST_IDLE), "response not loaded")

endmodule

@@ sim/fire_zone_table_point_check_checker.sv @@
`timescale 1ns / 100ps

module fire_zone_table_point_check_checker import fzt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending
);

   localparam int NPZ = PRIORITY_ZONES_DEF;
   localparam int NNZ = NOFIRE_ZONES_DEF;

   typedef logic signed [COORD_BITS-1:0] coord_t;
   typedef coord_t zone_t [8];

   zone_t pz_table [NPZ];
   zone_t nz_table [NNZ];
   int pz_used, nz_used, cur_zone;
   bit have_sel;
   rsp_type rsp_expected [$];

   assign pending = rsp_expected.size();

   function automatic int edge_sign(longint px, longint pzc, longint ax, longint az,
                                    longint bx, longint bz);
      longint lhs, rhs;
      lhs = (pzc - az) * (bx - ax);
      rhs = (px - ax) * (bz - az);
      if (lhs < rhs) return -1;
      if (lhs > rhs) return 1;
      return 0;
   endfunction

   function automatic bit point_inside(zone_t c, coord_t px, coord_t pzc);
      bit neg;
      int s, a, b;
      neg = edge_sign(px, pzc, c[0], c[1], c[2], c[3]) < 0;
      for (int k = 1; k < 4; k++) begin
         a = k * 2;
         b = ((k + 1) % 4) * 2;
         s = edge_sign(px, pzc, c[a], c[a+1], c[b], c[b+1]);
         if ((neg && s > 0) || (!neg && s < 0)) return 0;
      end
      return 1;
   endfunction

   task automatic select_previous();
      if (pz_used == 0) begin
         have_sel = 0; cur_zone = 0;
      end else if (!have_sel || cur_zone == 0) begin
         have_sel = 1; cur_zone = pz_used - 1;
      end else cur_zone--;
   endtask

   task automatic drop_priority(int idx);
      for (int i = idx; i + 1 < pz_used; i++) pz_table[i] = pz_table[i+1];
      pz_used--;
      if (have_sel && cur_zone >= pz_used) select_previous();
   endtask

   task automatic drop_nofire(int idx);
      for (int i = idx; i + 1 < nz_used; i++) nz_table[i] = nz_table[i+1];
      nz_used--;
   endtask

   // Advance the zone tables by one request and queue the response it causes
   task automatic predict_response(req_type r);
      rsp_type e;
      zone_t c;
      bit ok;
      c = '{r.corner1_x, r.corner1_z, r.corner2_x, r.corner2_z,
            r.corner3_x, r.corner3_z, r.corner4_x, r.corner4_z};
      e = '0;
      case (r.kind)
         KIND_ADD_PFZ: begin
            if (pz_used >= NPZ) drop_priority(0);
            pz_table[pz_used] = c; pz_used++;
         end
         KIND_ADD_NFZ: begin
            if (nz_used >= NNZ) drop_nofire(0);
            nz_table[nz_used] = c; nz_used++;
         end
         KIND_DEL_PFZ: if (r.zone_index < pz_used) drop_priority(r.zone_index);
                       else e.status = 1;
         KIND_DEL_NFZ: if (r.zone_index < nz_used) drop_nofire(r.zone_index);
                       else e.status = 1;
         KIND_NEXT: begin
            if (pz_used == 0) begin
               have_sel = 0; cur_zone = 0;
            end else if (!have_sel) begin
               have_sel = 1; cur_zone = 0;
            end else begin
               cur_zone++;
               if (cur_zone >= pz_used) cur_zone = 0;
            end
         end
         KIND_PREVIOUS: select_previous();
         KIND_DESELECT: begin
            have_sel = 0; cur_zone = 0;
         end
         KIND_DEL_CURRENT: if (have_sel && cur_zone < pz_used) drop_priority(cur_zone);
         KIND_CHECK: begin
            ok = 1;
            if (have_sel && cur_zone < pz_used &&
                !point_inside(pz_table[cur_zone], r.point_x, r.point_z)) ok = 0;
            for (int i = 0; ok && i < nz_used; i++)
               if (point_inside(nz_table[i], r.point_x, r.point_z)) ok = 0;
            e.target_valid = ok;
         end
         default: ;
      endcase
      e.zone_selected = have_sel;
      e.selected_zone = have_sel ? cur_zone[3:0] : 4'd0;
      e.priority_count = pz_used[4:0];
      e.nofire_count = nz_used[2:0];
      rsp_expected.push_back(e);
   endtask

   // Watch both channels at every rising edge
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         pz_used = 0; nz_used = 0; have_sel = 0; cur_zone = 0;
         rsp_expected.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (rsp_expected.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               e = rsp_expected.pop_front();
               if (rsp_data.target_valid !== e.target_valid) begin
                  $error("target_valid exp %0d got %0d", e.target_valid, rsp_data.target_valid);
                  fail_count++;
               end
               if (rsp_data.status !== e.status) begin
                  $error("status exp %0d got %0d", e.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.zone_selected !== e.zone_selected) begin
                  $error("zone_selected exp %0d got %0d", e.zone_selected,
                         rsp_data.zone_selected);
                  fail_count++;
               end
               if (rsp_data.selected_zone !== e.selected_zone) begin
                  $error("selected_zone exp %0d got %0d", e.selected_zone,
                         rsp_data.selected_zone);
                  fail_count++;
               end
               if (rsp_data.priority_count !== e.priority_count) begin
                  $error("priority_count exp %0d got %0d", e.priority_count,
                         rsp_data.priority_count);
                  fail_count++;
               end
               if (rsp_data.nofire_count !== e.nofire_count) begin
                  $error("nofire_count exp %0d got %0d", e.nofire_count,
                         rsp_data.nofire_count);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) predict_response(req_data);
      end
   end

endmodule

@@ sim/tb_fire_zone_table_point_check.sv @@
`timescale 1ns / 100ps

module tb_fire_zone_table_point_check import fzt_pkg::*;;

   typedef logic signed [COORD_BITS-1:0] coord_t;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   bit      idle_on = 1;

   always #2 clock = ~clock;

   fire_zone_table_point_check DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   fire_zone_table_point_check_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending)
   );

   // Stall the response side in random bursts
   initial begin
      @(negedge clock);
      forever begin
         if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
         rsp_stall <= 0;
         repeat ($urandom_range(1, 20)) @(negedge clock);
      end
   end

   function automatic coord_t rand_coord(bit near);
      case ($urandom_range(0, 9))
         0: return coord_t'(24'h7fffff);
         1: return coord_t'(24'h800000);
         2: return coord_t'(0);
         3, 4, 5: return coord_t'($urandom);
         default: return near ? coord_t'($signed($urandom_range(0, 200)) - 100)
                              : coord_t'($urandom);
      endcase
   endfunction

   // Hand one request to the block and hold it until accepted
   task automatic send_request(req_type r);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 16)) @(negedge clock);
      req_data <= r;
      req_valid <= 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      req_valid <= 0;
   endtask

   task automatic send_zone(logic [3:0] kind, coord_t x0, coord_t z0, coord_t x1, coord_t z1);
      req_type r;
      r = '0;
      r.kind = kind;
      r.corner1_x = x0; r.corner1_z = z0;
      r.corner2_x = x1; r.corner2_z = z0;
      r.corner3_x = x1; r.corner3_z = z1;
      r.corner4_x = x0; r.corner4_z = z1;
      send_request(r);
   endtask

   task automatic send_op(logic [3:0] kind, logic [3:0] idx, coord_t px, coord_t pz);
      req_type r;
      r = '0;
      r.kind = kind; r.zone_index = idx; r.point_x = px; r.point_z = pz;
      send_request(r);
   endtask

   task automatic drain();
      while (pending != 0) @(negedge clock);
   endtask

   initial begin
      req_type r;
      int n;
      repeat (6) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: empty-table selects and deletes, square zones, boundary points, unknown kinds
      send_op(KIND_NEXT, 0, 0, 0);
      send_op(KIND_PREVIOUS, 0, 0, 0);
      send_op(KIND_DEL_CURRENT, 0, 0, 0);
      send_op(KIND_DEL_PFZ, 15, 0, 0);
      send_op(KIND_DEL_NFZ, 0, 0, 0);
      send_op(KIND_CHECK, 0, 24'h7fffff, 24'h800000);
      send_zone(KIND_ADD_PFZ, -100, -100, 100, 100);
      send_zone(KIND_ADD_PFZ, 24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff);
      send_zone(KIND_ADD_NFZ, 0, 0, 50, 50);
      send_op(KIND_DEL_PFZ, 0, 0, 0);
      send_op(KIND_PREVIOUS, 0, 0, 0);
      send_op(KIND_CHECK, 0, 100, 100);
      send_op(KIND_CHECK, 0, 25, 25);
      send_op(KIND_CHECK, 0, 24'h7fffff, 24'h7fffff);
      send_op(KIND_NEXT, 0, 0, 0);
      send_op(KIND_DESELECT, 0, 0, 0);
      send_op(KIND_DEL_PFZ, 0, 0, 0);
      send_op(4'd9, 0, 0, 0);
      send_op(4'd15, 4'hf, 0, 0);
      send_op(KIND_DEL_NFZ, 0, 0, 0);
      drain();

      // Random: many near-origin zones so checks can land inside, plus full-range and extreme values
      for (int i = 0; i < 900; i++) begin
         if (i == 450) drain();
         if (i == 800) idle_on = 0;
         r = '0;
         n = $urandom_range(0, 99);
         if (n < 30) r.kind = KIND_ADD_PFZ;
         else if (n < 42) r.kind = KIND_ADD_NFZ;
         else if (n < 50) r.kind = KIND_DEL_PFZ;
         else if (n < 55) r.kind = KIND_DEL_NFZ;
         else if (n < 62) r.kind = KIND_NEXT;
         else if (n < 68) r.kind = KIND_PREVIOUS;
         else if (n < 71) r.kind = KIND_DESELECT;
         else if (n < 76) r.kind = KIND_DEL_CURRENT;
         else if (n < 97) r.kind = KIND_CHECK;
         else r.kind = 4'($urandom_range(9, 15));
         r.zone_index = $urandom_range(0, 3) == 0 ? 4'($urandom) : 4'($urandom_range(0, 5));
         r.point_x = rand_coord(1); r.point_z = rand_coord(1);
         r.corner1_x = rand_coord(1); r.corner1_z = rand_coord(1);
         r.corner2_x = rand_coord(1); r.corner2_z = rand_coord(1);
         r.corner3_x = rand_coord(1); r.corner3_z = rand_coord(1);
         r.corner4_x = rand_coord(1); r.corner4_z = rand_coord(1);
         send_request(r);
      end

      drain();
      repeat (600) @(negedge clock);
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   initial begin
      #4000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
